@@ rtl/clmd_pkg.sv @@
package clmd_pkg;

    // payload widths fixed by the item format
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int M_TDATA_W = 56;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // defaults for the size parameters, the reset frame size and the minimum size
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int SIZE_RESET     = 1024;
    localparam int SIZE_MIN       = 3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

@@ rtl/cross_local_minimum_detector_unit.sv @@
// cross (four neighbor) local minimum detector
//
// s_* channel: one signed 32-bit pixel per item, frame in row-major order.
// m_* channel: one item per local minimum found: value, row and column of an
//   interior pixel that is strictly below its up, left, right and down pixels.
// cfg_* channel: register 0 is frame_width, register 1 is frame_height;
//   values below 3 act as 3, values above the max size act as the max.
//   cfg_ready is always high; write only while the block is idle.
//
// throughput: one pixel per cycle while s_tready is high. each pixel does one read and one write
//   on each of two line memories (row above, row two above), both in the
//   accept cycle, so the memories set the rate at one item a cycle.
// a minimum is tested in the cycle after the pixel below it is accepted and is
//   pushed into the queue then; m_tvalid rises once the registered count holds it.
// results wait in a four-entry queue; s_tready drops only when the queue
//   together with the item under test could overflow, so a stalled receiver
//   stops the input once the queue fills with minima, and nothing is lost.
// reset clears the row/column counters, the queue and the frame size
//   (1024 x 1024); the line memories hold no reset value and are filled by
//   the first two rows of a frame.
module cross_local_minimum_detector_unit #(
    parameter int MAX_WIDTH  = clmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = clmd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [clmd_pkg::VALUE_W-1:0]         s_tdata,   // [31:0] pixel_value
    // minimum items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] min_value, [41:32] min_row, [51:42] min_col, [55:52] zero
    output logic [clmd_pkg::M_TDATA_W-1:0]       m_tdata,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [clmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [clmd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    localparam int VW = clmd_pkg::VALUE_W;
    localparam int PW = clmd_pkg::POS_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [31:0]      cfg_ext;
    logic [31:0]      width_clamp;
    logic [31:0]      height_clamp;

    assign cfg_ready = 1'b1;
    assign cfg_ext   = 32'(cfg_data);

    always_comb
    begin
        if (cfg_ext < 32'(clmd_pkg::SIZE_MIN))
        begin
            width_clamp  = 32'(clmd_pkg::SIZE_MIN);
            height_clamp = 32'(clmd_pkg::SIZE_MIN);
        end
        else
        begin
            width_clamp  = (cfg_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_ext;
            height_clamp = (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'((clmd_pkg::SIZE_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : clmd_pkg::SIZE_RESET);
            height_reg <= HGT_W'((clmd_pkg::SIZE_RESET > MAX_HEIGHT) ?
                                 MAX_HEIGHT : clmd_pkg::SIZE_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                clmd_pkg::REG_FRAME_WIDTH:  width_reg  <= width_clamp[WID_W-1:0];
                clmd_pkg::REG_FRAME_HEIGHT: height_reg <= height_clamp[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------
    logic             s_acc;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [31:0]      col_ext, row_ext, col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic             test_now;

    assign s_acc   = s_tvalid && s_tready;
    assign col_ext = 32'(col_reg);
    assign row_ext = 32'(row_reg);
    assign col_inc = col_ext + 32'd1;
    assign row_inc = row_ext + 32'd1;

    assign col_wrap = col_inc >= 32'(width_reg);
    assign row_wrap = row_inc >= 32'(height_reg);

    // interior centre one row up, with its down pixel arriving now
    assign test_now = (row_ext >= 32'd2) && (row_ext < 32'(height_reg)) &&
                      (col_ext >= 32'd1) && (col_ext + 32'd2 <= 32'(width_reg));

    always_comb
    begin
        col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        row_next = row_reg;
        if (col_wrap)
        begin
            row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // line memories
    // prev_rd_reg holds the row-above entry of the column that comes next,
    // fetched one item ahead; older is read before its entry is replaced
    // ------------------------------------------------------------------
    logic [VW-1:0] prev_mem  [MAX_WIDTH];
    logic [VW-1:0] older_mem [MAX_WIDTH];
    logic [VW-1:0] prev_rd_reg;
    logic [VW-1:0] older_rd_reg;
    logic [VW-1:0] left_reg;

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            prev_mem[col_reg]  <= s_tdata;
            older_mem[col_reg] <= prev_rd_reg;
            prev_rd_reg        <= prev_mem[col_next];
            older_rd_reg       <= older_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // compare stage: centre, left and down are registered at accept,
    // right and up are the memory reads, registered at the same accept
    // ------------------------------------------------------------------
    logic          s2_valid_reg;
    logic          s2_test_reg;
    logic [VW-1:0] s2_centre_reg;
    logic [VW-1:0] s2_left_reg;
    logic [VW-1:0] s2_down_reg;
    logic [PW-1:0] s2_row_reg;
    logic [PW-1:0] s2_col_reg;
    logic [31:0]   row_m1;
    logic          is_min;

    assign row_m1 = row_ext - 32'd1;

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            left_reg      <= prev_rd_reg;
            s2_centre_reg <= prev_rd_reg;
            s2_left_reg   <= left_reg;
            s2_down_reg   <= s_tdata;
            s2_row_reg    <= row_m1[PW-1:0];
            s2_col_reg    <= col_ext[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_test_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s_acc;
            s2_test_reg  <= s_acc && test_now;
        end
    end

    assign is_min = s2_valid_reg && s2_test_reg &&
                    ($signed(s2_centre_reg) < $signed(older_rd_reg)) &&
                    ($signed(s2_centre_reg) < $signed(s2_left_reg)) &&
                    ($signed(s2_centre_reg) < $signed(prev_rd_reg)) &&
                    ($signed(s2_centre_reg) < $signed(s2_down_reg));

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    clmd_pkg::result_t                fifo_mem [clmd_pkg::FIFO_DEPTH];
    logic [clmd_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [clmd_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [clmd_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                             push, pop;
    clmd_pkg::result_t                push_item;
    clmd_pkg::result_t                head_item;

    assign push = is_min;
    assign pop  = m_tvalid && m_tready;

    assign push_item.value = s2_centre_reg;
    assign push_item.row   = s2_row_reg;
    assign push_item.col   = s2_col_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // room for the item under test plus the one accepted now
    assign s_tready = (32'(count_reg) + 32'(s2_valid_reg)) < 32'(clmd_pkg::FIFO_DEPTH);

    assign head_item = fifo_mem[rd_ptr_reg];
    assign m_tvalid  = count_reg != '0;
    assign m_tdata   = clmd_pkg::M_TDATA_W'(head_item);

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(clmd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < 32'(clmd_pkg::FIFO_DEPTH)) || pop)
        else $error("result pushed into full queue");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_tvalid)
        else $error("pushed result not presented");

    a_test_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        s2_test_reg |-> s2_valid_reg)
        else $error("test flag without item");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(MAX_WIDTH))
        else $error("column counter beyond line memory");

endmodule

@@ tb/sv/cross_local_minimum_detector_unit_tb.sv @@
module cross_local_minimum_detector_unit_tb;

    // run limits
    localparam int CYCLE_LIMIT  = 1000000;  // generous timeout, slowest run is far below
    localparam int DRAIN_CYCLES = 8;        // settling margin after the last predicted minimum is seen
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off for the pressure test
    localparam int RANDOM_PIXELS = 650;
    localparam int STORE_DEPTH  = clmd_pkg::MAX_WIDTH_DEF;

    // how a frame is filled with pixel values
    typedef enum int
    {
        FILL_NOISE,    // full 32-bit random values
        FILL_NEAR,     // a random base plus a small offset, many equal neighbors
        FILL_CHECKER   // low / high checkerboard, dense minima
    } fill_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [clmd_pkg::VALUE_W-1:0]   s_tdata;     // [31:0] pixel_value
    logic                           m_tvalid;
    logic                           m_tready;
    // [31:0] min_value, [41:32] min_row, [51:42] min_col
    logic [clmd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [clmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [clmd_pkg::CFG_W-1:0]     cfg_data;

    cross_local_minimum_detector_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: both line stores, the position of the next pixel, the frame size
    logic [clmd_pkg::VALUE_W-1:0] row_above     [STORE_DEPTH];
    logic [clmd_pkg::VALUE_W-1:0] row_two_above [STORE_DEPTH];
    int                           next_row;
    int                           next_col;
    int                           width_cfg;
    int                           height_cfg;

    // minima predicted but not yet seen on the output, oldest first
    clmd_pkg::result_t minima_q [$];
    clmd_pkg::result_t seen_min;
    clmd_pkg::result_t want_min;

    // run bookkeeping
    int          error_count;
    int          pixels_sent;
    int          minima_seen;
    int          input_stalls;
    int          cycle_count;
    int          config_writes;
    int          mid_frame_writes;

    // idling controls for the sender task (tx) and the receiver process (rx, hold requests)
    bit          tx_idling;
    bit          rx_idling;
    int          hold_requests;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // cycle counter, input stall counter and the timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready)
        begin
            input_stalls++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d minima still expected",
                     $time, cycle_count, minima_q.size());
            $display("cross_local_minimum_detector_unit verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off whenever a test asks for one
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        int burst_left;
        hold_seen  = 0;
        hold_left  = 0;
        burst_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                m_tready = 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                // this cycle is the first of the burst
                burst_left = $urandom_range(1, 12) - 1;
                m_tready   = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // checker: every accepted minimum item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_min = clmd_pkg::result_t'(m_tdata[$bits(clmd_pkg::result_t)-1:0]);
            if (minima_q.size() == 0)
            begin
                $display("%0t: minimum item with none expected: value %h row %0d col %0d",
                         $time, seen_min.value, seen_min.row, seen_min.col);
                error_count++;
            end
            else
            begin
                want_min = minima_q.pop_front();
                minima_seen++;
                if (seen_min.value !== want_min.value)
                begin
                    $display("%0t: min_value expected %h actual %h",
                             $time, want_min.value, seen_min.value);
                    error_count++;
                end
                if (seen_min.row !== want_min.row)
                begin
                    $display("%0t: min_row expected %0d actual %0d",
                             $time, want_min.row, seen_min.row);
                    error_count++;
                end
                if (seen_min.col !== want_min.col)
                begin
                    $display("%0t: min_col expected %0d actual %0d",
                             $time, want_min.col, seen_min.col);
                    error_count++;
                end
            end
        end
    end

    // size register write: low 11 bits, below 3 acts as 3, above the max acts as the max
    function automatic int clamp_size(logic [clmd_pkg::CFG_W-1:0] raw, int max_size);
        int v;
        v = raw;
        if (v < clmd_pkg::SIZE_MIN)
        begin
            return clmd_pkg::SIZE_MIN;
        end
        if (v > max_size)
        begin
            return max_size;
        end
        return v;
    endfunction

    // one accepted pixel: test the centre above it, shift the line stores, step the counters
    function automatic void predict_minimum(logic [clmd_pkg::VALUE_W-1:0] pixel);
        logic [clmd_pkg::VALUE_W-1:0] centre;
        logic [clmd_pkg::VALUE_W-1:0] up;
        logic [clmd_pkg::VALUE_W-1:0] left;
        logic [clmd_pkg::VALUE_W-1:0] right;
        clmd_pkg::result_t            found;
        int                           r;
        int                           c;
        r = next_row;
        c = next_col;
        if (c < STORE_DEPTH)
        begin
            // interior centres only; a counter past a shrunk bound tests nothing
            if (r >= 2 && r < height_cfg && c >= 1 && c + 2 <= width_cfg)
            begin
                centre = row_above[c];
                up     = row_two_above[c];
                left   = row_two_above[c - 1];   // already holds the centre row
                right  = row_above[c + 1];
                if ($signed(centre) < $signed(up) && $signed(centre) < $signed(left) &&
                    $signed(centre) < $signed(right) && $signed(centre) < $signed(pixel))
                begin
                    found.value = centre;
                    found.row   = clmd_pkg::POS_W'(r - 1);
                    found.col   = clmd_pkg::POS_W'(c);
                    minima_q.push_back(found);
                end
            end
            row_two_above[c] = row_above[c];
            row_above[c]     = pixel;
        end
        c++;
        if (c >= width_cfg)
        begin
            c = 0;
            r++;
            if (r >= height_cfg)
            begin
                r = 0;
            end
        end
        next_row = r;
        next_col = c;
    endfunction

    function automatic logic [clmd_pkg::VALUE_W-1:0] make_pixel(fill_t style,
                                                                logic [clmd_pkg::VALUE_W-1:0] base,
                                                                int r, int c);
        case (style)
            FILL_NEAR:    return base + $urandom_range(0, 7);
            FILL_CHECKER: return ((r + c) % 2 != 0) ? base + 32'd100 + $urandom_range(0, 50)
                                                    : base + $urandom_range(0, 50);
            default:      return $urandom();
        endcase
    endfunction

    // offer one pixel item, maybe after an idle burst, and predict once it is taken
    task automatic send_pixel(logic [clmd_pkg::VALUE_W-1:0] pixel);
        int gap;
        if (tx_idling && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = pixel;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_minimum(pixel);
        pixels_sent++;
    endtask

    task automatic send_rows(int width, int rows, fill_t style);
        logic [clmd_pkg::VALUE_W-1:0] base;
        base = $urandom();
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < width; c++)
            begin
                send_pixel(make_pixel(style, base, r, c));
            end
        end
    endtask

    // stop offering, let every predicted minimum arrive, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (minima_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; only called with the block idle
    task automatic write_reg(logic [clmd_pkg::CFG_IDX_W-1:0] index,
                             logic [clmd_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (index == clmd_pkg::REG_FRAME_WIDTH)
        begin
            width_cfg = clamp_size(value, clmd_pkg::MAX_WIDTH_DEF);
        end
        else if (index == clmd_pkg::REG_FRAME_HEIGHT)
        begin
            height_cfg = clamp_size(value, clmd_pkg::MAX_HEIGHT_DEF);
        end
        config_writes++;
        if (next_row != 0 || next_col != 0)
        begin
            mid_frame_writes++;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(int width, int height);
        wait_idle();
        write_reg(clmd_pkg::REG_FRAME_WIDTH, clmd_pkg::CFG_W'(width));
        write_reg(clmd_pkg::REG_FRAME_HEIGHT, clmd_pkg::CFG_W'(height));
    endtask

    // random pixels until the counters wrap back to the top of a frame
    task automatic finish_frame();
        while (next_row != 0 || next_col != 0)
        begin
            send_pixel($urandom());
        end
    endtask

    // one 3x3 frame built around its single interior centre
    task automatic send_cross(logic [clmd_pkg::VALUE_W-1:0] corner,
                              logic [clmd_pkg::VALUE_W-1:0] up,
                              logic [clmd_pkg::VALUE_W-1:0] left,
                              logic [clmd_pkg::VALUE_W-1:0] centre,
                              logic [clmd_pkg::VALUE_W-1:0] right,
                              logic [clmd_pkg::VALUE_W-1:0] down);
        send_pixel(corner);
        send_pixel(up);
        send_pixel(corner);
        send_pixel(left);
        send_pixel(centre);
        send_pixel(right);
        send_pixel(corner);
        send_pixel(down);
        send_pixel(corner);
    endtask

    // both sizes written out of range high, then cut down in the middle of the frame:
    // first the width with the column counter past it, later the height with the row
    // counter past it; the 24 columns in between fill the line store entries used later
    task automatic test_wide_rows();
        write_reg(clmd_pkg::REG_FRAME_HEIGHT, 11'd2047);
        write_reg(clmd_pkg::REG_FRAME_WIDTH, 11'd2047);
        repeat (40) send_pixel($urandom());
        wait_idle();
        write_reg(clmd_pkg::REG_FRAME_WIDTH, 11'd24);
        // column 40 then wraps; rows 1 and 2, and six pixels of row 3
        repeat (55) send_pixel($urandom());
        wait_idle();
        // row and column both past the new bounds: no test, back to the top next pixel
        write_reg(clmd_pkg::REG_FRAME_HEIGHT, 11'd0);
        write_reg(clmd_pkg::REG_FRAME_WIDTH, 11'd2);
        finish_frame();
    endtask

    // smallest frame with extreme values: strict and signed compares
    task automatic test_corner_values();
        // most negative centre under most positive neighbors
        send_cross(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // centre equal to the pixel below: not a minimum
        send_cross(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0000, 32'hFFFF_FFFF);
        // right neighbor negative, so a large positive centre is not below it
        send_cross(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                   32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    // narrowest frame, forty rows tall, width written out of range low
    task automatic test_tall_frame();
        wait_idle();
        write_reg(clmd_pkg::REG_FRAME_WIDTH, 11'd1);
        write_reg(clmd_pkg::REG_FRAME_HEIGHT, 11'd40);
        send_rows(clmd_pkg::SIZE_MIN, 40, FILL_NEAR);
    endtask

    // size changes in the middle of a frame; growing reuses stale store entries
    task automatic test_mid_frame_resize();
        set_size(6, 6);
        repeat (14)
        begin
            repeat ($urandom_range(1, 20)) send_pixel($urandom_range(0, 15));
            wait_idle();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(clmd_pkg::REG_FRAME_WIDTH, clmd_pkg::CFG_W'($urandom_range(0, 20)));
            end
            else
            begin
                write_reg(clmd_pkg::REG_FRAME_HEIGHT, clmd_pkg::CFG_W'($urandom_range(0, 20)));
            end
        end
        finish_frame();
    endtask

    // whole frames of random size and content, mostly small
    task automatic test_random_frames();
        int start;
        int w;
        int h;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 100) : $urandom_range(3, 12);
            h = $urandom_range(3, 10);
            if (w != width_cfg || h != height_cfg || $urandom_range(0, 2) == 0)
            begin
                set_size(w, h);
            end
            // some frames run with no idling at all
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            send_rows(width_cfg, height_cfg, fill_t'($urandom_range(0, 2)));
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // receiver holds off while dense minima keep coming: the queue fills, input stalls
    task automatic test_output_backpressure();
        set_size(16, 16);
        tx_idling = 1'b0;
        hold_requests++;
        send_rows(16, 16, FILL_CHECKER);
        wait_idle();
        tx_idling = 1'b1;
    endtask

    // closing stretch at full rate on both sides
    task automatic test_back_to_back();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        set_size(8, 8);
        send_rows(8, 8, FILL_CHECKER);
        send_rows(8, 8, FILL_NEAR);
        send_rows(8, 8, FILL_CHECKER);
        wait_idle();
    endtask

    initial
    begin
        // every input known from time zero, reset held low before the tests start
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_requests = 0;
        error_count   = 0;
        pixels_sent   = 0;
        minima_seen   = 0;
        input_stalls  = 0;
        cycle_count   = 0;
        config_writes = 0;
        mid_frame_writes = 0;
        next_row      = 0;
        next_col      = 0;
        width_cfg     = clmd_pkg::SIZE_RESET;
        height_cfg    = clmd_pkg::SIZE_RESET;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wide_rows();
        test_corner_values();
        test_tall_frame();
        test_mid_frame_resize();
        test_random_frames();
        test_output_backpressure();
        test_back_to_back();

        $display("run covered %0d pixels and %0d minima over %0d register writes (%0d mid-frame)",
                 pixels_sent, minima_seen, config_writes, mid_frame_writes);
        $display("frames 3 to 100 wide plus a clamped 1024 row, %0d cycles of input stall",
                 input_stalls);
        if (error_count == 0)
        begin
            $display("cross_local_minimum_detector_unit verification clean");
        end
        else
        begin
            $display("cross_local_minimum_detector_unit verification failed");
        end
        $finish;
    end

endmodule
